FILE: src/wsc_pkg.sv
package wsc_pkg;

  // default sizes of the word store
  localparam int MaxWordsDef   = 16;
  localparam int MaxWordLenDef = 16;

  // fixed field widths of the input and result words
  localparam int CmdW    = 2;
  localparam int SlotW   = 4;
  localparam int OffsetW = 4;
  localparam int ByteW   = 8;
  localparam int EntLenW = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_DICT_CHAR = 2'd0,
    CMD_TEXT_BYTE = 2'd1,
    CMD_NEW_TEXT  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

endpackage

FILE: src/wsc_if.sv
interface wsc_in_if import wsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    cmd;
  logic [SlotW-1:0]   word_slot;
  logic [OffsetW-1:0] char_offset;
  logic [ByteW-1:0]   char_byte;
  logic [EntLenW-1:0] entry_length;
  logic               final_byte;

  modport source (
    output valid, cmd, word_slot, char_offset, char_byte, entry_length, final_byte,
    input  ready
  );
  modport sink (
    input  valid, cmd, word_slot, char_offset, char_byte, entry_length, final_byte,
    output ready
  );
endinterface

interface wsc_out_if;
  logic valid;
  logic ready;
  logic prefix_breakable;
  logic is_last;

  modport source (output valid, prefix_breakable, is_last, input ready);
  modport sink (input valid, prefix_breakable, is_last, output ready);
endinterface

FILE: src/word_segmentation_checker.sv
// Word-break checker. Dictionary characters (cmd 0) and new-text commands (cmd 2) are
// taken one per cycle while the block is idle and give no result. Each text byte (cmd 1)
// gives one result word telling whether the text so far splits into dictionary words; on
// the byte flagged final_byte the bit answers for the whole text. After a text byte is
// accepted, the dictionary entries are read from the word store one per cycle through its
// single read port, each row compared in full against the recent bytes, then the result
// is moved into the output register; no new input is taken until then. The output register
// lets the next word be accepted while a result still waits. The dictionary survives
// cmd 2; only the text history is cleared. Entries whose characters were never written
// give undefined matches.
module word_segmentation_checker import wsc_pkg::*; #(
  parameter int MAX_WORDS    = MaxWordsDef,
  parameter int MAX_WORD_LEN = MaxWordLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wsc_in_if.sink     in_i,
  wsc_out_if.source  out_o
);

  localparam int WIdxW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CIdxW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int LenW  = $clog2(MAX_WORD_LEN + 1);

  // word store: one row of characters per entry, plus lengths with valid bits
  logic [MAX_WORD_LEN-1:0][ByteW-1:0] dict_mem [MAX_WORDS];
  logic [LenW-1:0]                    len_mem  [MAX_WORDS];
  logic [MAX_WORDS-1:0]               len_vld_q;

  logic [MAX_WORD_LEN-1:0][ByteW-1:0] recent_q, recent_d;
  logic [MAX_WORD_LEN-1:0]            reach_q, reach_d;
  logic [LenW-1:0]                    bytes_seen_q, bytes_seen_d;

  state_e            state_q, state_d;
  logic [WIdxW-1:0]  issue_idx_q;
  logic              issuing_q;
  logic              rd_vld_q;
  logic              hit_q;
  logic              last_q;
  logic              res_q;

  logic [MAX_WORD_LEN-1:0][ByteW-1:0] rd_row_q;
  logic [LenW-1:0]                    rd_len_q;
  logic                               rd_lvld_q;

  logic              out_vld_q;
  logic              out_bit_q;
  logic              out_last_q;

  logic              in_acc;
  logic              wr_ok;
  logic [LenW-1:0]   len_wr;
  logic              lanes_ok;
  logic              reach_sel;
  logic              word_hit;
  logic              hit_all;
  logic              scan_end;
  logic              out_free;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign wr_ok  = (32'(in_i.word_slot) < MAX_WORDS) && (32'(in_i.char_offset) < MAX_WORD_LEN);
  assign len_wr = (32'(in_i.entry_length) > MAX_WORD_LEN) ? '0 : LenW'(in_i.entry_length);

  // dictionary writes
  always_ff @(posedge clk_i) begin
    if (in_acc && cmd_e'(in_i.cmd) == CMD_DICT_CHAR && wr_ok) begin
      dict_mem[WIdxW'(in_i.word_slot)][CIdxW'(in_i.char_offset)] <= in_i.char_byte;
      len_mem[WIdxW'(in_i.word_slot)] <= len_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_vld_q <= '0;
    end else if (in_acc && cmd_e'(in_i.cmd) == CMD_DICT_CHAR && wr_ok) begin
      len_vld_q[WIdxW'(in_i.word_slot)] <= 1'b1;
    end
  end

  // scan read port, data registered
  always_ff @(posedge clk_i) begin
    if (issuing_q) begin
      rd_row_q  <= dict_mem[issue_idx_q];
      rd_len_q  <= len_mem[issue_idx_q];
      rd_lvld_q <= len_vld_q[issue_idx_q];
    end
  end

  // compare one entry against the newest bytes, all characters at once
  always_comb begin
    lanes_ok  = 1'b1;
    reach_sel = 1'b0;
    for (int j = 0; j < MAX_WORD_LEN; j++) begin
      if (32'(rd_len_q) == j + 1) begin
        reach_sel = reach_q[j];
      end
    end
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      for (int j = 0; j < MAX_WORD_LEN; j++) begin
        if (k + j + 1 == 32'(rd_len_q) && rd_row_q[k] != recent_q[j]) begin
          lanes_ok = 1'b0;
        end
      end
    end
    word_hit = rd_lvld_q && (rd_len_q != '0) && (rd_len_q <= bytes_seen_q) &&
               reach_sel && lanes_ok;
  end

  assign hit_all  = hit_q || (rd_vld_q && word_hit);
  assign scan_end = (state_q == ST_SCAN) && !issuing_q && rd_vld_q;
  assign out_free = !out_vld_q || out_o.ready;

  always_comb begin
    state_d      = state_q;
    recent_d     = recent_q;
    reach_d      = reach_q;
    bytes_seen_d = bytes_seen_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_e'(in_i.cmd))
            CMD_TEXT_BYTE: begin
              recent_d[0] = in_i.char_byte;
              for (int i = 1; i < MAX_WORD_LEN; i++) begin
                recent_d[i] = recent_q[i-1];
              end
              if (bytes_seen_q != LenW'(MAX_WORD_LEN)) begin
                bytes_seen_d = bytes_seen_q + 1'b1;
              end
              state_d = ST_SCAN;
            end
            CMD_NEW_TEXT: begin
              recent_d     = '0;
              reach_d      = '0;
              reach_d[0]   = 1'b1;
              bytes_seen_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          reach_d[0] = hit_all;
          for (int i = 1; i < MAX_WORD_LEN; i++) begin
            reach_d[i] = reach_q[i-1];
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      recent_q     <= '0;
      reach_q      <= MAX_WORD_LEN'(1);
      bytes_seen_q <= '0;
      issue_idx_q  <= '0;
      issuing_q    <= 1'b0;
      rd_vld_q     <= 1'b0;
      hit_q        <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      recent_q     <= recent_d;
      reach_q      <= reach_d;
      bytes_seen_q <= bytes_seen_d;
      rd_vld_q     <= issuing_q;
      if (in_acc && cmd_e'(in_i.cmd) == CMD_TEXT_BYTE) begin
        issue_idx_q <= '0;
        issuing_q   <= 1'b1;
        hit_q       <= 1'b0;
      end else begin
        if (issuing_q) begin
          if (issue_idx_q == WIdxW'(MAX_WORDS - 1)) begin
            issuing_q <= 1'b0;
          end else begin
            issue_idx_q <= issue_idx_q + 1'b1;
          end
        end
        if (rd_vld_q) begin
          hit_q <= hit_all;
        end
      end
      if (state_q == ST_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_acc && cmd_e'(in_i.cmd) == CMD_TEXT_BYTE) begin
      last_q <= in_i.final_byte;
    end
    if (scan_end) begin
      res_q <= hit_all;
    end
    if (state_q == ST_DONE && out_free) begin
      out_bit_q  <= res_q;
      out_last_q <= last_q;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.prefix_breakable = out_bit_q;
  assign out_o.is_last          = out_last_q;

  // a result word appears only after a finished scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_DONE))
    else $error("result word without a finished scan");

  // the read pipeline is busy only during a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issuing_q || rd_vld_q) |-> (state_q == ST_SCAN))
    else $error("store read outside a scan");

  // every entry is read before the scan ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_end |-> (issue_idx_q == WIdxW'(MAX_WORDS - 1)))
    else $error("scan ended before the last entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(bytes_seen_q) <= MAX_WORD_LEN)
    else $error("byte count beyond saturation");

endmodule

FILE: tb/sv/word_segmentation_checker_tb.sv
`timescale 1ns / 100ps

module word_segmentation_checker_tb;
  import wsc_pkg::*;

  localparam int NumSlots = MaxWordsDef;
  localparam int WordLen  = MaxWordLenDef;

  // cmd code the block ignores
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [SlotW-1:0]   slot;
    logic [OffsetW-1:0] offset;
    logic [ByteW-1:0]   chr;
    logic [EntLenW-1:0] len;
    logic               last;
    logic               has_exp;
    logic               exp_brk;
  } stim_t;

  typedef struct packed {
    logic brk;
    logic last;
  } verdict_t;

  // directed rows: cmd, slot, offset, byte, length, final, typed expectation, value
  localparam stim_t DirRows [24] = '{
    '{CMD_TEXT_BYTE, 4'd0,  4'd0,  8'h00, 5'd0,  1'b0, 1'b1, 1'b0},
    '{CMD_TEXT_BYTE, 4'd15, 4'd15, 8'hff, 5'd16, 1'b1, 1'b1, 1'b0},
    '{CmdUnused,     4'd15, 4'd15, 8'hff, 5'd31, 1'b1, 1'b0, 1'b0},
    '{CMD_NEW_TEXT,  4'd0,  4'd0,  8'h00, 5'd0,  1'b0, 1'b0, 1'b0},
    '{CMD_DICT_CHAR, 4'd0,  4'd0,  8'h61, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_DICT_CHAR, 4'd15, 4'd0,  8'h62, 5'd2,  1'b0, 1'b0, 1'b0},
    '{CMD_DICT_CHAR, 4'd15, 4'd1,  8'h63, 5'd2,  1'b0, 1'b0, 1'b0},
    '{CMD_TEXT_BYTE, 4'd0,  4'd0,  8'h61, 5'd0,  1'b0, 1'b1, 1'b1},
    '{CMD_TEXT_BYTE, 4'd0,  4'd0,  8'h62, 5'd0,  1'b0, 1'b0, 1'b0},
    '{CMD_TEXT_BYTE, 4'd0,  4'd0,  8'h63, 5'd0,  1'b1, 1'b0, 1'b0},
    '{CMD_TEXT_BYTE, 4'd0,  4'd0,  8'h78, 5'd0,  1'b0, 1'b0, 1'b0},
    '{CMD_TEXT_BYTE, 4'd0,  4'd0,  8'h61, 5'd0,  1'b0, 1'b0, 1'b0},
    '{CMD_NEW_TEXT,  4'd15, 4'd15, 8'hff, 5'd31, 1'b1, 1'b0, 1'b0},
    '{CMD_DICT_CHAR, 4'd4,  4'd0,  8'h00, 5'd2,  1'b0, 1'b0, 1'b0},
    '{CMD_DICT_CHAR, 4'd4,  4'd1,  8'h00, 5'd2,  1'b0, 1'b0, 1'b0},
    '{CMD_TEXT_BYTE, 4'd0,  4'd0,  8'h00, 5'd0,  1'b0, 1'b0, 1'b0},
    '{CMD_TEXT_BYTE, 4'd0,  4'd0,  8'h00, 5'd0,  1'b0, 1'b0, 1'b0},
    '{CMD_NEW_TEXT,  4'd0,  4'd0,  8'h00, 5'd0,  1'b0, 1'b0, 1'b0},
    '{CMD_TEXT_BYTE, 4'd0,  4'd0,  8'h63, 5'd0,  1'b0, 1'b0, 1'b0},
    '{CMD_DICT_CHAR, 4'd1,  4'd0,  8'h7a, 5'd17, 1'b0, 1'b0, 1'b0},
    '{CMD_DICT_CHAR, 4'd1,  4'd0,  8'h7a, 5'd0,  1'b0, 1'b0, 1'b0},
    '{CMD_DICT_CHAR, 4'd1,  4'd0,  8'h7a, 5'd31, 1'b0, 1'b0, 1'b0},
    '{CMD_TEXT_BYTE, 4'd0,  4'd0,  8'h7a, 5'd0,  1'b1, 1'b0, 1'b0},
    '{CmdUnused,     4'd0,  4'd0,  8'h00, 5'd0,  1'b0, 1'b0, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  wsc_in_if  in_if ();
  wsc_out_if out_if ();

  word_segmentation_checker u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predictor state
  bit [ByteW-1:0]   dict_rows [NumSlots][WordLen];
  bit [EntLenW-1:0] dict_len [NumSlots];
  bit [WordLen-1:0] row_written [NumSlots];
  bit [ByteW-1:0]   text_tail [WordLen];
  bit [WordLen:0]   reach_bits = (WordLen + 1)'(1);
  bit [EntLenW-1:0] tail_fill;

  verdict_t pending_verdicts [$];
  int       mismatches;
  int       items_sent;
  int       verdicts_seen;
  bit       src_idle;
  bit       snk_idle;

  function automatic void clear_text();
    for (int i = 0; i < WordLen; i++) text_tail[i] = '0;
    reach_bits = (WordLen + 1)'(1);
    tail_fill  = '0;
  endfunction

  // shift in a text byte and decide whether the prefix now ending is reachable
  function automatic logic next_reach(input logic [ByteW-1:0] b);
    int  wl;
    logic hit;
    logic same;
    for (int i = WordLen - 1; i > 0; i--) text_tail[i] = text_tail[i-1];
    text_tail[0] = b;
    if (tail_fill < WordLen) tail_fill++;
    hit = 1'b0;
    for (int w = 0; w < NumSlots; w++) begin
      wl = int'(dict_len[w]);
      if (wl != 0 && wl <= int'(tail_fill) && reach_bits[wl-1]) begin
        same = 1'b1;
        for (int k = 0; k < wl; k++) begin
          if (dict_rows[w][k] != text_tail[wl-1-k]) same = 1'b0;
        end
        if (same) hit = 1'b1;
      end
    end
    reach_bits = {reach_bits[WordLen-1:0], hit};
    return hit;
  endfunction

  function automatic void track_item(input stim_t s);
    logic brk;
    case (s.cmd)
      CMD_DICT_CHAR: begin
        dict_rows[s.slot][s.offset] = s.chr;
        dict_len[s.slot] = (s.len > WordLen) ? '0 : s.len;
        row_written[s.slot][s.offset] = 1'b1;
      end
      CMD_NEW_TEXT: clear_text();
      CMD_TEXT_BYTE: begin
        brk = next_reach(s.chr);
        if (s.has_exp) brk = s.exp_brk;
        pending_verdicts.push_back('{brk: brk, last: s.last});
      end
      default: ;
    endcase
  endfunction

  function automatic stim_t mk(input logic [CmdW-1:0] cmd, input logic [SlotW-1:0] slot,
                               input logic [OffsetW-1:0] offset, input logic [ByteW-1:0] chr,
                               input logic [EntLenW-1:0] len, input logic last);
    return '{cmd, slot, offset, chr, len, last, 1'b0, 1'b0};
  endfunction

  task automatic put_item(input stim_t s);
    int gap;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.cmd          <= s.cmd;
    in_if.word_slot    <= s.slot;
    in_if.char_offset  <= s.offset;
    in_if.char_byte    <= s.chr;
    in_if.entry_length <= s.len;
    in_if.final_byte   <= s.last;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    if (s.cmd != CmdUnused) items_sent++;
    track_item(s);
  endtask

  task automatic load_word(input int slot, input int wl, input logic [ByteW-1:0] alpha [3]);
    for (int k = 0; k < wl; k++) begin
      put_item(mk(CMD_DICT_CHAR, SlotW'(slot), OffsetW'(k), alpha[$urandom_range(0, 2)],
                  EntLenW'(wl), 1'b0));
    end
  endtask

  // stray dictionary write; the length never covers a character that was never written
  task automatic poke_dict();
    int slot;
    int offset;
    int run;
    int pick;
    logic [WordLen-1:0] mask;
    logic [EntLenW-1:0] wl;
    slot   = $urandom_range(0, NumSlots - 1);
    offset = $urandom_range(0, WordLen - 1);
    mask   = row_written[slot];
    mask[offset] = 1'b1;
    run = 0;
    while (run < WordLen && mask[run]) run++;
    pick = $urandom_range(0, 3);
    if (pick == 0 || run == 0) wl = '0;
    else if (pick == 1) wl = EntLenW'($urandom_range(WordLen + 1, 31));
    else wl = EntLenW'($urandom_range(1, run));
    put_item(mk(CMD_DICT_CHAR, SlotW'(slot), OffsetW'(offset), ByteW'($urandom_range(0, 255)),
                wl, 1'($urandom_range(0, 1))));
  endtask

  // text built mostly from stored words, with a stray byte now and then
  task automatic send_text(input logic [ByteW-1:0] alpha [3]);
    int pieces;
    int slot;
    logic [ByteW-1:0] txt [$];
    int live [$];
    for (int s = 0; s < NumSlots; s++) if (dict_len[s] != 0) live.push_back(s);
    pieces = $urandom_range(1, 5);
    for (int p = 0; p < pieces; p++) begin
      if (live.size() == 0 || $urandom_range(0, 5) == 0) begin
        txt.push_back(alpha[$urandom_range(0, 2)]);
      end else if ($urandom_range(0, 19) == 0) begin
        txt.push_back(ByteW'($urandom_range(0, 255)));
      end else begin
        slot = live[$urandom_range(0, live.size() - 1)];
        for (int k = 0; k < dict_len[slot]; k++) txt.push_back(dict_rows[slot][k]);
      end
    end
    for (int i = 0; i < txt.size(); i++) begin
      put_item(mk(CMD_TEXT_BYTE, SlotW'($urandom_range(0, 15)), OffsetW'($urandom_range(0, 15)),
                  txt[i], EntLenW'($urandom_range(0, 31)), i == txt.size() - 1));
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stalls, plus long hold-offs so the block backs up
  initial begin
    int stall;
    verdict_t want;
    out_if.ready <= 1'b0;
    snk_idle = 1'b1;
    stall = $urandom_range(0, 9);
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        verdicts_seen++;
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: breakable=%b last=%b",
                     out_if.prefix_breakable, out_if.is_last);
        end else begin
          want = pending_verdicts.pop_front();
          if (out_if.prefix_breakable !== want.brk || out_if.is_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d: expected breakable=%b last=%b, got breakable=%b last=%b",
                       verdicts_seen, want.brk, want.last,
                       out_if.prefix_breakable, out_if.is_last);
          end
        end
        if (verdicts_seen % 64 == 0) snk_idle = $urandom_range(0, 3) != 0;
        stall = snk_idle ? $urandom_range(0, 9) : 0;
        if (verdicts_seen == 150 || verdicts_seen == 1000) stall = 400;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [ByteW-1:0] alpha [3];
    int nwords;
    int ntexts;
    in_if.valid        <= 1'b0;
    in_if.cmd          <= CMD_NEW_TEXT;
    in_if.word_slot    <= '0;
    in_if.char_offset  <= '0;
    in_if.char_byte    <= '0;
    in_if.entry_length <= '0;
    in_if.final_byte   <= 1'b0;
    src_idle = 1'b1;
    clear_text();
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    for (int r = 0; r < 24; r++) put_item(DirRows[r]);

    while (items_sent < 1800) begin
      src_idle = $urandom_range(0, 3) != 0;
      for (int i = 0; i < 3; i++) alpha[i] = ByteW'($urandom_range(0, 255));
      nwords = $urandom_range(2, 5);
      for (int i = 0; i < nwords; i++) begin
        load_word($urandom_range(0, NumSlots - 1),
                  ($urandom_range(0, 7) == 0) ? WordLen : $urandom_range(1, 4), alpha);
      end
      ntexts = $urandom_range(3, 6);
      for (int t = 0; t < ntexts; t++) begin
        // now and then a text runs on without being reopened
        if ($urandom_range(0, 9) != 0)
          put_item(mk(CMD_NEW_TEXT, SlotW'($urandom_range(0, 15)),
                      OffsetW'($urandom_range(0, 15)), ByteW'($urandom_range(0, 255)),
                      EntLenW'($urandom_range(0, 31)), 1'($urandom_range(0, 1))));
        if ($urandom_range(0, 7) == 0) poke_dict();
        if ($urandom_range(0, 11) == 0)
          put_item(mk(CmdUnused, SlotW'($urandom_range(0, 15)),
                      OffsetW'($urandom_range(0, 15)), ByteW'($urandom_range(0, 255)),
                      EntLenW'($urandom_range(0, 31)), 1'($urandom_range(0, 1))));
        send_text(alpha);
      end
    end

    in_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: word_segmentation_checker.f
src/wsc_pkg.sv
src/wsc_if.sv
src/word_segmentation_checker.sv
tb/sv/word_segmentation_checker_tb.sv
